@@ src/stl_pkg.sv @@
// Shared types and constants for the Scheme token lexer.
// Holds the lexer mode, result kind and error codes and the result word layout.
// No dependencies.
package stl_pkg;

  // Lexer modes.
  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_TOKEN   = 3'd1,
    M_STRING  = 3'd2,
    M_ESCAPE  = 3'd3,
    M_COMMENT = 3'd4
  } lex_mode_t;

  // Result kinds.
  typedef enum logic [3:0] {
    K_OPEN    = 4'd0,
    K_CLOSE   = 4'd1,
    K_STRING  = 4'd2,
    K_SYMBOL  = 4'd3,
    K_INTEGER = 4'd4,
    K_DECIMAL = 4'd5,
    K_BOOLEAN = 4'd6,
    K_TEXT    = 4'd7,
    K_ERROR   = 4'd8
  } kind_t;

  // Error codes carried with an error result.
  typedef enum logic [1:0] {
    E_NONE     = 2'd0,
    E_STRING   = 2'd1,
    E_TOKEN    = 2'd2,
    E_UNTOKEN  = 2'd3
  } err_t;

  // One result word.
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         char_out;
    logic signed [31:0] number_value;
    logic [4:0]         fraction_digits;
    err_t               error_code;
    logic               last;
  } result_t;

  // Depth of the result queue; an accepted byte needs room for two words.
  localparam int RQ_DEPTH = 4;

  // Character codes.
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

endpackage

@@ src/stl_if.sv @@
// Handshake channels of the Scheme token lexer: source bytes in, result words out.
// Depends on stl_pkg for the kind and error code types.
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface stl_out_if import stl_pkg::*; ;
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [7:0]         char_out;
  logic signed [31:0] number_value;
  logic [4:0]         fraction_digits;
  err_t               error_code;
  logic               last;

  modport source (output valid, output kind, output char_out, output number_value,
                  output fraction_digits, output error_code, output last, input ready);
  modport sink (input valid, input kind, input char_out, input number_value,
                input fraction_digits, input error_code, input last, output ready);
endinterface

@@ src/scheme_token_lexer_unit.sv @@
// Scheme token lexer top level: byte lexer state, token classifier and result queue.
// Depends on stl_pkg and the channel interfaces in stl_if.sv.
//
//   Channel       Modport  Word                                         Per byte
//   char_stream   sink     in_byte, end_of_input                        1 word in
//   token_stream  source   kind, char_out, number_value, fraction_...   0 to 2 words out
//
// One source byte is accepted per cycle while char_stream.ready is high; its state update
// happens in the accept cycle. Its zero, one or two result words enter a four-word result
// queue at the same edge, and the queue head drives token_stream; words leave one a cycle
// while token_stream.ready is high. The sink stalls only when the queue holds more than two
// words, so steady bytes with one word each run at one byte per clock. rst is synchronous.
module scheme_token_lexer_unit
  import stl_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  stl_in_if.sink     char_stream,
  stl_out_if.source  token_stream
);

  localparam int VW     = VALUE_WIDTH;
  localparam int EW     = (VW > 32) ? VW : 32;
  localparam int PTR_W  = $clog2(RQ_DEPTH);
  localparam int CNT_W  = $clog2(RQ_DEPTH + 1);
  localparam logic [VW-1:0] CAP    = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] CAP_M1 = {1'b0, {(VW-1){1'b1}}};

  // Character classes.
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_initial(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2F, 8'h3A,
      8'h3E, 8'h3C, 8'h3D, 8'h3F, 8'h7E, 8'h5F, 8'h5E: r = 1'b1;
      [8'h61:8'h7A], [8'h41:8'h5A]:                   r = 1'b1;
      default:                                          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_subsequent(input logic [7:0] c);
    return is_initial(c) || is_digit(c) || (c == CH_POINT) || is_sign(c);
  endfunction

  function automatic result_t mk(input kind_t k, input logic [7:0] ch,
                                 input logic [31:0] val, input logic [4:0] frac,
                                 input err_t e);
    result_t r;
    r.kind            = k;
    r.char_out        = ch;
    r.number_value    = val;
    r.fraction_digits = frac;
    r.error_code      = e;
    r.last            = 1'b0;
    return r;
  endfunction

  // Lexer and token state.
  lex_mode_t     lex_mode, lex_mode_next;
  logic [1:0]    token_length, token_length_next;
  logic [7:0]    first_byte, first_byte_next;
  logic [7:0]    second_byte, second_byte_next;
  logic          digits_only_rest, digits_only_rest_next;
  logic [1:0]    point_count, point_count_next;
  logic          ident_ok, ident_ok_next;
  logic [VW-1:0] mantissa_acc, mantissa_acc_next;
  logic [4:0]    frac_count, frac_count_next;

  // Result queue.
  result_t          rq [RQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] rq_count, rq_count_next;

  logic       accept, pop;
  logic [7:0] c;
  logic       fin_v, pri_v, do_idle, start_tok, add_byte, body_en;
  result_t    fin_res, pri_res, slot0, slot1;
  logic [1:0] push_n;
  logic [VW+3:0] prod;
  logic [3:0]    digit;

  // Classifier inputs taken from the token registers.
  logic          tok_sgn, tok_is_num;
  logic [1:0]    tok_body;
  logic [VW-1:0] pos_v, neg_v;
  logic [EW-1:0] ext_v;

  assign c      = char_stream.in_byte;
  assign accept = char_stream.valid && char_stream.ready;
  assign pop    = token_stream.valid && token_stream.ready;
  assign char_stream.ready = (rq_count < CNT_W'(RQ_DEPTH - 1));

  // Token classification at a delimiter.
  always_comb begin
    tok_sgn    = is_sign(first_byte);
    tok_body   = token_length - {1'b0, tok_sgn};
    tok_is_num = digits_only_rest && (point_count <= 2'd1) && (tok_body > point_count);
    pos_v      = (mantissa_acc > CAP_M1) ? CAP_M1 : mantissa_acc;
    neg_v      = -mantissa_acc;
    if (first_byte == CH_MINUS) begin
      ext_v = EW'($signed(neg_v));
    end else begin
      ext_v = EW'(pos_v);
    end
    if (tok_is_num) begin
      if (point_count == 2'd0) begin
        fin_res = mk(K_INTEGER, 8'd0, ext_v[31:0], 5'd0, E_NONE);
      end else begin
        fin_res = mk(K_DECIMAL, 8'd0, ext_v[31:0], frac_count, E_NONE);
      end
    end else if (ident_ok || ((token_length == 2'd1) && tok_sgn)) begin
      fin_res = mk(K_SYMBOL, 8'd0, 32'd0, 5'd0, E_NONE);
    end else if ((token_length == 2'd2) && (first_byte == CH_HASH) &&
                 ((second_byte == CH_LOWER_F) || (second_byte == CH_LOWER_T))) begin
      fin_res = mk(K_BOOLEAN, 8'd0, {31'd0, second_byte == CH_LOWER_T}, 5'd0, E_NONE);
    end else begin
      fin_res = mk(K_ERROR, 8'd0, 32'd0, 5'd0, E_UNTOKEN);
    end
  end

  // Lexer next state and the words one byte produces.
  always_comb begin
    lex_mode_next         = lex_mode;
    token_length_next     = token_length;
    first_byte_next       = first_byte;
    second_byte_next      = second_byte;
    digits_only_rest_next = digits_only_rest;
    point_count_next      = point_count;
    ident_ok_next         = ident_ok;
    mantissa_acc_next     = mantissa_acc;
    frac_count_next       = frac_count;
    fin_v     = 1'b0;
    pri_v     = 1'b0;
    pri_res   = mk(K_TEXT, c, 32'd0, 5'd0, E_NONE);
    do_idle   = 1'b0;
    start_tok = 1'b0;
    add_byte  = 1'b0;
    body_en   = 1'b0;
    prod      = '0;
    digit     = c[3:0];

    if (char_stream.end_of_input) begin
      // End of text flushes any open token or string as an error.
      if (lex_mode == M_TOKEN) begin
        pri_v   = 1'b1;
        pri_res = mk(K_ERROR, 8'd0, 32'd0, 5'd0, E_TOKEN);
      end else if ((lex_mode == M_STRING) || (lex_mode == M_ESCAPE)) begin
        pri_v   = 1'b1;
        pri_res = mk(K_ERROR, 8'd0, 32'd0, 5'd0, E_STRING);
      end
      lex_mode_next = M_IDLE;
      start_tok     = 1'b1;
    end else begin
      unique case (lex_mode)
        M_TOKEN: begin
          if ((c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SPACE) ||
              (c == CH_NEWLINE)) begin
            fin_v   = 1'b1;
            do_idle = 1'b1;
          end else begin
            add_byte = 1'b1;
            pri_v    = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_DQUOTE) begin
            lex_mode_next = M_IDLE;
            pri_v         = 1'b1;
            pri_res       = mk(K_STRING, 8'd0, 32'd0, 5'd0, E_NONE);
          end else if (c == CH_BSLASH) begin
            lex_mode_next = M_ESCAPE;
          end else begin
            pri_v = 1'b1;
          end
        end
        M_ESCAPE: begin
          lex_mode_next = M_STRING;
          pri_v         = 1'b1;
          if (c == CH_LOWER_N) begin
            pri_res.char_out = CH_NEWLINE;
          end else if (c == CH_LOWER_T) begin
            pri_res.char_out = CH_TAB;
          end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
            pri_res.char_out = c;
          end else begin
            pri_res.char_out = CH_BSLASH;
          end
        end
        M_COMMENT: begin
          if (c == CH_NEWLINE) begin
            lex_mode_next = M_IDLE;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // A byte seen outside any token, string or comment.
      if (do_idle) begin
        lex_mode_next = M_IDLE;
        if (c == CH_LPAREN) begin
          pri_v   = 1'b1;
          pri_res = mk(K_OPEN, 8'd0, 32'd0, 5'd0, E_NONE);
        end else if (c == CH_RPAREN) begin
          pri_v   = 1'b1;
          pri_res = mk(K_CLOSE, 8'd0, 32'd0, 5'd0, E_NONE);
        end else if ((c == CH_SPACE) || (c == CH_NEWLINE)) begin
          lex_mode_next = M_IDLE;
        end else if (c == CH_DQUOTE) begin
          lex_mode_next = M_STRING;
        end else if (c == CH_SEMI) begin
          lex_mode_next = M_COMMENT;
        end else begin
          lex_mode_next = M_TOKEN;
          start_tok     = 1'b1;
          add_byte      = 1'b1;
          pri_v         = 1'b1;
        end
      end
    end

    // A fresh token starts from cleared flags.
    if (start_tok) begin
      token_length_next     = 2'd0;
      first_byte_next       = 8'd0;
      second_byte_next      = 8'd0;
      digits_only_rest_next = 1'b1;
      point_count_next      = 2'd0;
      ident_ok_next         = 1'b1;
      mantissa_acc_next     = '0;
      frac_count_next       = 5'd0;
    end

    // Fold one token byte into the classification flags.
    if (add_byte) begin
      if (token_length_next == 2'd0) begin
        first_byte_next = c;
        ident_ok_next   = is_initial(c);
        body_en         = !is_sign(c);
      end else begin
        if (token_length_next == 2'd1) begin
          second_byte_next = c;
        end
        if (!is_subsequent(c)) begin
          ident_ok_next = 1'b0;
        end
        body_en = 1'b1;
      end
      if (body_en) begin
        if (is_digit(c)) begin
          prod = {mantissa_acc_next, 3'b000} + {2'b00, mantissa_acc_next, 1'b0} +
                 (VW+4)'(digit);
          if (prod > {4'b0000, CAP}) begin
            mantissa_acc_next = CAP;
          end else begin
            mantissa_acc_next = prod[VW-1:0];
          end
          if ((point_count_next == 2'd1) && (frac_count_next != 5'd31)) begin
            frac_count_next = frac_count_next + 5'd1;
          end
        end else if (c == CH_POINT) begin
          if (point_count_next != 2'd2) begin
            point_count_next = point_count_next + 2'd1;
          end
        end else begin
          digits_only_rest_next = 1'b0;
        end
      end
      if (token_length_next != 2'd3) begin
        token_length_next = token_length_next + 2'd1;
      end
    end
  end

  // Order the words for the queue and mark the final one.
  always_comb begin
    push_n = {1'b0, fin_v} + {1'b0, pri_v};
    slot0  = fin_v ? fin_res : pri_res;
    slot1  = pri_res;
    slot0.last = (push_n == 2'd1);
    slot1.last = 1'b1;
    rq_count_next = rq_count + (accept ? CNT_W'(push_n) : CNT_W'(0)) -
                    (pop ? CNT_W'(1) : CNT_W'(0));
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= M_IDLE;
      token_length     <= 2'd0;
      first_byte       <= 8'd0;
      second_byte      <= 8'd0;
      digits_only_rest <= 1'b1;
      point_count      <= 2'd0;
      ident_ok         <= 1'b1;
      mantissa_acc     <= '0;
      frac_count       <= 5'd0;
    end else if (accept) begin
      lex_mode         <= lex_mode_next;
      token_length     <= token_length_next;
      first_byte       <= first_byte_next;
      second_byte      <= second_byte_next;
      digits_only_rest <= digits_only_rest_next;
      point_count      <= point_count_next;
      ident_ok         <= ident_ok_next;
      mantissa_acc     <= mantissa_acc_next;
      frac_count       <= frac_count_next;
    end
  end

  // Result queue pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      rq_count <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      rq_count <= rq_count_next;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (accept && (push_n != 2'd0)) begin
      rq[wr_ptr] <= slot0;
    end
    if (accept && (push_n == 2'd2)) begin
      rq[wr_ptr + PTR_W'(1)] <= slot1;
    end
  end

  // Head of the queue drives the output word.
  assign token_stream.valid           = (rq_count != '0);
  assign token_stream.kind            = rq[rd_ptr].kind;
  assign token_stream.char_out        = rq[rd_ptr].char_out;
  assign token_stream.number_value    = rq[rd_ptr].number_value;
  assign token_stream.fraction_digits = rq[rd_ptr].fraction_digits;
  assign token_stream.error_code      = rq[rd_ptr].error_code;
  assign token_stream.last            = rq[rd_ptr].last;

  // Checks on queue occupancy and lexer behavior.
  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
      rq_count <= CNT_W'(RQ_DEPTH))
    else $error("result queue count exceeds its depth");

  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
      accept && char_stream.end_of_input |=> lex_mode == M_IDLE)
    else $error("lexer not idle after end of text");

  a_open_paren: assert property (@(posedge clk) disable iff (rst)
      accept && !char_stream.end_of_input && (rq_count == '0) && (lex_mode == M_IDLE) &&
      (char_stream.in_byte == CH_LPAREN)
      |=> token_stream.valid && (token_stream.kind == K_OPEN) && token_stream.last)
    else $error("open parenthesis word missing");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
      token_stream.valid && (token_stream.kind == K_ERROR) |-> token_stream.error_code != E_NONE)
    else $error("error word without an error code");

endmodule
